// ===== sv/c2e_pkg.sv =====
// Shared types, constants and tables for the calendar-to-epoch converter.
package c2e_pkg;

  localparam logic [11:0] YEAR_BASE    = 12'd1900;
  localparam logic [11:0] OFFSET_LIMIT = 12'd1000;
  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [11:0] LAST_YEAR    = 12'd2099;

  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [8:0] HOURS_PER_DAY = 9'd24;
  localparam logic [8:0] MINS_PER_HOUR = 9'd60;
  localparam logic [8:0] SECS_PER_MIN  = 9'd60;
  localparam logic [8:0] UNIT_SCALE    = 9'd1;
  localparam logic [3:0] FEBRUARY      = 4'd1;
  localparam logic [9:0] EPOCH_WEEKDAY = 10'd4;   // 1970-01-01 was a Thursday
  localparam logic [3:0] WEEK_LEN      = 4'd7;

  // One decoded request, as the sequencer needs it.
  typedef struct packed {
    logic       ok;     // effective year within 1970..2099
    logic [7:0] span;   // whole years since 1970
    logic [5:0] leaps;  // leap years from 1970 up to the year before
    logic [9:0] doy;    // day of year, two's complement (day zero in January gives -1)
  } c2e_item_t;

  // Days in all months before month m; months above eleven take the whole year.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

  // Residue modulo seven by folding octal digits (eight is one modulo seven).
  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = 5'(x[9]) + 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    r  = (s2 >= WEEK_LEN) ? (s2 - WEEK_LEN) : s2;
    return r[2:0];
  endfunction

endpackage

// ===== sv/c2e_decode.sv =====
// Request decoder: effective year, range check, year span, leap count and day of year.
module c2e_decode
  import c2e_pkg::*;
(
  input  logic [11:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_of_month,
  output c2e_item_t   item
);

  logic [11:0] eff_year;
  logic [11:0] span_full;
  logic [8:0]  span_inc;
  logic        leap_add;

  always_comb begin
    eff_year  = (year_in < OFFSET_LIMIT) ? (year_in + YEAR_BASE) : year_in;
    span_full = eff_year - EPOCH_YEAR;
    span_inc  = {1'b0, span_full[7:0]} + 9'd1;
    leap_add  = (month_in > FEBRUARY) || (month_in == FEBRUARY + 4'd1) ?
                (eff_year[1:0] == 2'b00) : 1'b0;
    item.ok    = (eff_year >= EPOCH_YEAR) && (eff_year <= LAST_YEAR);
    item.span  = span_full[7:0];
    item.leaps = span_inc[7:2];
    item.doy   = {1'b0, cum_days(month_in)} + 10'(leap_add) + 10'(day_of_month) - 10'd1;
  end

endmodule

// ===== sv/c2e_mac.sv =====
// Shared multiply-accumulate unit: y = a * b + c, modulo 2^32.
module c2e_mac
  import c2e_pkg::*;
(
  input  logic [31:0] a,
  input  logic [8:0]  b,
  input  logic [31:0] c,
  output logic [31:0] y
);

  logic [40:0] prod;

  assign prod = {9'b0, a} * {32'b0, b};
  assign y    = prod[31:0] + c;

endmodule

// ===== sv/calendar_to_epoch_seconds_unit.sv =====
// Top level: UTC calendar date and time to seconds since 1970, with sequencer.
//
//   channel  direction  handshake             payload
//   in_      request    in_valid / in_stall   year, month, day, hour, minute, second
//   out_     result     out_valid / out_stall epoch seconds, day of year, weekday, valid_res
//
// After accept, a request steps through the shared multiply-accumulate unit
// (years, day, hours, minutes, seconds); the result register and out_valid load
// together at the end of the last step. A year outside 1970..2099 skips straight
// to the last step, which loads a zero result.
// The unit takes one request at a time; in_stall is high from accept until the
// result is loaded, and a new request may be accepted while the previous result
// still waits in the output register. If that register is still full and out_stall
// is high when the next result is ready, the sequencer holds in its last step.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the
// output register.
module calendar_to_epoch_seconds_unit
  import c2e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_of_month,
  input  logic [4:0]  in_hour_in,
  input  logic [5:0]  in_minute_in,
  input  logic [5:0]  in_second_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_epoch_seconds,
  output logic [8:0]  out_day_of_year,
  output logic [2:0]  out_weekday,
  output logic        out_valid_res
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_YEAR = 6'b000010,
    ST_DOY  = 6'b000100,
    ST_HOUR = 6'b001000,
    ST_MIN  = 6'b010000,
    ST_SEC  = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  c2e_item_t   dec;
  c2e_item_t   item_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [2:0]  wd_r;
  logic [31:0] acc_r;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] mac_a, mac_c, mac_y;
  logic [8:0]  mac_b;
  logic        accept, load_out;
  logic [9:0]  wd_sum;

  c2e_decode u_decode (
    .year_in      (in_year_in),
    .month_in     (in_month_in),
    .day_of_month (in_day_of_month),
    .item         (dec)
  );

  c2e_mac u_mac (
    .a (mac_a),
    .b (mac_b),
    .c (mac_c),
    .y (mac_y)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_out  = (state_r == ST_SEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // Weekday folds 365 to one modulo seven, so only span, leaps and day count matter.
  assign wd_sum = 10'(item_r.span) + 10'(item_r.leaps) + item_r.doy + EPOCH_WEEKDAY;

  // Operand select for the shared unit: one Horner step per state.
  always_comb begin
    mac_a = acc_r;
    mac_b = UNIT_SCALE;
    mac_c = 32'd0;
    unique case (state_r)
      ST_YEAR: begin
        mac_a = 32'(item_r.span);
        mac_b = DAYS_PER_YEAR;
        mac_c = 32'(item_r.leaps);
      end
      ST_DOY: begin
        mac_c = {{22{item_r.doy[9]}}, item_r.doy};
      end
      ST_HOUR: begin
        mac_b = HOURS_PER_DAY;
        mac_c = 32'(hour_r);
      end
      ST_MIN: begin
        mac_b = MINS_PER_HOUR;
        mac_c = 32'(min_r);
      end
      ST_SEC: begin
        mac_b = SECS_PER_MIN;
        mac_c = 32'(sec_r);
      end
      default: begin
        mac_a = acc_r;
      end
    endcase
  end

  // Sequencer: advance one step a cycle, skip to the last step on a bad year, and hold there until the result loads.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = dec.ok ? ST_YEAR : ST_SEC;
      ST_YEAR: state_nxt = ST_DOY;
      ST_DOY:  state_nxt = ST_HOUR;
      ST_HOUR: state_nxt = ST_MIN;
      ST_MIN:  state_nxt = ST_SEC;
      ST_SEC:  if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request, register the weekday, step the accumulator and load the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= dec;
      hour_r <= in_hour_in;
      min_r  <= in_minute_in;
      sec_r  <= in_second_in;
    end
    if (state_r == ST_YEAR) begin
      wd_r <= mod7(wd_sum);
    end
    if ((state_r == ST_YEAR) || (state_r == ST_DOY) || (state_r == ST_HOUR) ||
        (state_r == ST_MIN)) begin
      acc_r <= mac_y;
    end
    if (load_out) begin
      out_epoch_seconds <= item_r.ok ? mac_y : 32'd0;
      out_day_of_year   <= item_r.ok ? item_r.doy[8:0] : 9'd0;
      out_weekday       <= item_r.ok ? wd_r : 3'd0;
      out_valid_res     <= item_r.ok;
    end
  end

endmodule

// ===== verif/tb_calendar_to_epoch_seconds_unit.sv =====
// Self-checking testbench for the calendar date to epoch seconds converter.
module tb_calendar_to_epoch_seconds_unit;
  import c2e_pkg::*;

  // Give up after this many cycles in which neither channel moves anything.
  localparam int QUIET_LIMIT = 4000;
  // Let the pipeline settle for this many cycles after the last result.
  localparam int TAIL_CYCLES = 24;
  // Print only this many mismatch lines; count the rest silently.
  localparam int MAX_REPORTS = 40;

  // Month lengths of a common year, January first.
  localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  // Years either side of the accepted window and of the 1900 offset threshold.
  localparam int unsigned EDGE_YEARS [10] =
    '{1969, 1970, 2099, 2100, 69, 70, 199, 200, 999, 1000};

  // One broken-down date and time as it enters the block.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_t;

  // One converted stamp as it leaves the block.
  typedef struct packed {
    logic [31:0] secs;
    logic [8:0]  doy;
    logic [2:0]  wday;
    logic        ok;
  } stamp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_year_in = '0;
  logic [3:0]  in_month_in = '0;
  logic [4:0]  in_day_of_month = '0;
  logic [4:0]  in_hour_in = '0;
  logic [5:0]  in_minute_in = '0;
  logic [5:0]  in_second_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_epoch_seconds;
  logic [8:0]  out_day_of_year;
  logic [2:0]  out_weekday;
  logic        out_valid_res;

  // Stamps predicted for accepted requests, oldest first.
  stamp_t pending_stamps[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int stamps_checked = 0;
  int rejected_years = 0;
  int quiet_cycles = 0;

  calendar_to_epoch_seconds_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_year_in        (in_year_in),
    .in_month_in       (in_month_in),
    .in_day_of_month   (in_day_of_month),
    .in_hour_in        (in_hour_in),
    .in_minute_in      (in_minute_in),
    .in_second_in      (in_second_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds),
    .out_day_of_year   (out_day_of_year),
    .out_weekday       (out_weekday),
    .out_valid_res     (out_valid_res)
  );

  always #10 clk = ~clk;

  // Predict the stamp for one date. The leap rule is plain divisibility by four,
  // and nothing is range checked apart from the year, so oversized days, hours,
  // minutes and seconds simply carry. Day zero in January 1970 gives a day count
  // of minus one, which wraps in the day of year and in the seconds.
  function automatic stamp_t civil_to_stamp(input civil_t c);
    stamp_t      s;
    int unsigned yr;
    int          days;
    int          m;
    logic [31:0] secs;
    s  = '0;
    yr = c.year;
    if (yr < OFFSET_LIMIT) yr += YEAR_BASE;
    if (yr < EPOCH_YEAR || yr > LAST_YEAR) return s;
    days = 0;
    for (m = 0; m < 12 && m < int'(c.month); m++) days += MONTH_LEN[m];
    if (c.month > FEBRUARY && (yr % 4) == 0) days++;
    days += int'(c.day) - 1;
    s.doy = 9'(days);
    // Whole years since 1970 and the leap days among them.
    days += int'((yr - EPOCH_YEAR) * DAYS_PER_YEAR + (yr - (EPOCH_YEAR - 1)) / 4);
    s.wday = 3'((days + int'(EPOCH_WEEKDAY)) % int'(WEEK_LEN));
    secs   = 32'(days) * HOURS_PER_DAY + c.hour;
    secs   = secs * MINS_PER_HOUR + c.minute;
    secs   = secs * SECS_PER_MIN + c.second;
    s.secs = secs;
    s.ok   = 1'b1;
    return s;
  endfunction

  function automatic civil_t civil(input int y, input int mo, input int d,
                                   input int h, input int mi, input int sc);
    civil_t c;
    c = '{12'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(sc)};
    return c;
  endfunction

  // Mostly well-formed dates in the window, with offsets, edge years and
  // full-width noise mixed in so that every bit of every field toggles.
  function automatic civil_t random_civil();
    civil_t c;
    int     pick;
    pick = $urandom_range(0, 9);
    c = civil($urandom_range(1970, 2099), $urandom_range(0, 11), $urandom_range(1, 31),
              $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 60));
    case (pick)
      6: begin
        c.year = 12'($urandom_range(70, 199));
      end
      7: begin
        c = civil_t'($urandom());
        c.year = 12'($urandom());
      end
      8: begin
        c = civil_t'($urandom());
        c.year = 12'(EDGE_YEARS[$urandom_range(0, 9)]);
      end
      9: begin
        c.month  = 4'($urandom());
        c.day    = 5'($urandom());
        c.hour   = 5'($urandom());
        c.minute = 6'($urandom());
        c.second = 6'($urandom());
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Idle at random, then present one request and hold it until it is taken.
  // Valid is only lowered when an idle cycle follows, so it never toggles twice
  // in one step.
  task automatic send_request(input civil_t c);
    stamp_t s;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_year_in      <= c.year;
    in_month_in     <= c.month;
    in_day_of_month <= c.day;
    in_hour_in      <= c.hour;
    in_minute_in    <= c.minute;
    in_second_in    <= c.second;
    do @(posedge clk); while (in_stall);
    s = civil_to_stamp(c);
    pending_stamps.push_back(s);
    requests_sent++;
    if (!s.ok) rejected_years++;
  endtask

  // Drop valid and hold off until every predicted stamp has been collected.
  task automatic drain_stamps();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_stamps.size() != 0);
  endtask

  // Epoch origin, the last second of the window, and field extremes.
  task automatic test_field_extremes();
    send_request(civil(1970, 0, 1, 0, 0, 0));
    send_request(civil(70, 0, 1, 0, 0, 1));
    send_request(civil(2099, 11, 31, 23, 59, 60));
    send_request(civil(199, 11, 31, 23, 59, 59));
    send_request(civil(2038, 0, 19, 3, 14, 7));
    // All-ones in every small field: carries into the next unit.
    send_request(civil(2099, 15, 31, 31, 63, 63));
    send_request(civil(1985, 6, 31, 31, 63, 63));
  endtask

  // Years outside the window, via both the full and the offset form.
  task automatic test_year_window();
    send_request(civil(1969, 11, 31, 23, 59, 59));
    send_request(civil(2100, 0, 1, 0, 0, 0));
    send_request(civil(69, 5, 15, 12, 30, 30));
    send_request(civil(200, 5, 15, 12, 30, 30));
    send_request(civil(0, 0, 1, 0, 0, 0));
    send_request(civil(999, 3, 3, 3, 3, 3));
    send_request(civil(1000, 3, 3, 3, 3, 3));
    send_request(civil(4095, 15, 31, 31, 63, 63));
  endtask

  // Leap day only from March onward in a year divisible by four; months above
  // eleven take the whole year.
  task automatic test_month_overflow();
    send_request(civil(2000, 1, 29, 0, 0, 0));
    send_request(civil(2000, 2, 1, 0, 0, 0));
    send_request(civil(2001, 2, 1, 0, 0, 0));
    send_request(civil(2000, 12, 1, 0, 0, 0));
    send_request(civil(2001, 15, 1, 0, 0, 0));
    send_request(civil(1972, 11, 31, 0, 0, 0));
  endtask

  // Day zero: the day before the first, wrapping at the very start of 1970.
  task automatic test_day_zero();
    send_request(civil(1970, 0, 0, 0, 0, 0));
    send_request(civil(1970, 0, 0, 23, 59, 59));
    send_request(civil(2024, 2, 0, 12, 0, 0));
  endtask

  task automatic test_random_dates(input int count);
    repeat (count) send_request(random_civil());
  endtask

  // Wait for an empty pipeline, then restart with a burst.
  task automatic test_drain_pause();
    drain_stamps();
    test_random_dates(8);
  endtask

  // Collect results: compare each with the oldest prediction, field by field.
  task automatic check_stamp();
    stamp_t want;
    if (pending_stamps.size() == 0) begin
      flag_mismatch($sformatf("result with no request pending: secs %0d", out_epoch_seconds));
      return;
    end
    want = pending_stamps.pop_front();
    stamps_checked++;
    if (out_epoch_seconds !== want.secs)
      flag_mismatch($sformatf("epoch seconds %0d, want %0d", out_epoch_seconds, want.secs));
    if (out_day_of_year !== want.doy)
      flag_mismatch($sformatf("day of year %0d, want %0d", out_day_of_year, want.doy));
    if (out_weekday !== want.wday)
      flag_mismatch($sformatf("weekday %0d, want %0d", out_weekday, want.wday));
    if (out_valid_res !== want.ok)
      flag_mismatch($sformatf("valid_res %0b, want %0b", out_valid_res, want.ok));
  endtask

  // Sample the result channel and stall it at random for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_stamp();
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d requests sent, %0d results checked",
                 requests_sent, stamps_checked);
        $display("calendar_to_epoch_seconds_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    // Hold reset, then release it at a rising edge.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles lightly, receiver stalls heavily: results back up.
    send_idle_pct = 30;
    recv_idle_pct = 74;
    test_field_extremes();
    test_year_window();
    test_month_overflow();
    test_day_zero();
    test_random_dates(400);
    test_drain_pause();

    // Starve the block instead: long gaps on the request side.
    send_idle_pct = 74;
    recv_idle_pct = 30;
    test_random_dates(410);

    // Full throughput on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_dates(400);

    drain_stamps();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d dates (%0d outside 1970..2099) and checked %0d stamps,",
             requests_sent, rejected_years, stamps_checked);
    $display("covering edge years, month and field overflow, day zero and both stall mixes.");
    if (mismatches == 0) begin
      $display("calendar_to_epoch_seconds_unit: match");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("calendar_to_epoch_seconds_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/c2e_pkg.sv
sv/c2e_decode.sv
sv/c2e_mac.sv
sv/calendar_to_epoch_seconds_unit.sv
verif/tb_calendar_to_epoch_seconds_unit.sv
